// File: design/mrb_pkg.sv
package mrb_pkg;

  localparam int LVL_W = 7;
  localparam logic [LVL_W-1:0] NO_LEVEL = 7'd127;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Second block of a 64-byte message: pad byte, zeros, bit length 512.
  localparam logic [511:0] MERGE_PAD = {8'h80, 440'd0, 64'd512};

  typedef struct packed {
    logic busy;
    logic done;
  } sha_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Byte i of a hash word set moves to byte position 31-i (message order).
  function automatic logic [255:0] bswap256(input logic [255:0] x);
    logic [255:0] r;
    for (int i = 0; i < 32; i++) begin
      r[8*i +: 8] = x[255-8*i -: 8];
    end
    return r;
  endfunction

endpackage

// File: design/mrb_sha_core.sv
module mrb_sha_core
  import mrb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [511:0] blk,
  input  logic [255:0] init,
  output sha_stat_t    stat,
  output logic [255:0] digest
);

  logic        busy;
  logic        fin;
  logic        done;
  logic [5:0]  rnd;
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h0 [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_next;

  always_comb begin
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[rnd] + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_next = w[0] + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[9]
           + (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rnd <= '0;
      for (int j = 0; j < 16; j++) begin
        w[j] <= blk[511-32*j -: 32];
      end
      for (int j = 0; j < 8; j++) begin
        v[j]  <= init[255-32*j -: 32];
        h0[j] <= init[255-32*j -: 32];
      end
    end else if (busy) begin
      rnd <= rnd + 6'd1;
      for (int j = 0; j < 15; j++) begin
        w[j] <= w[j+1];
      end
      w[15] <= w_next;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end else if (fin) begin
      for (int j = 0; j < 8; j++) begin
        digest[255-32*j -: 32] <= h0[j] + v[j];
      end
    end
  end

  assign stat.busy = busy | fin;
  assign stat.done = done;

endmodule

// File: design/merkle_root_and_branch.sv
// Push: one merge per trailing zero of the new count.
// Finish: empty levels are scanned, then each odd level is lifted and merged up to the root.
// The shared SHA-256 round unit (one round a cycle, 64 rounds a block) sets the rate;
// a level read from the level store is registered. A new item is taken once the previous
// item's last result sits in the output register. Synchronous reset clears the leaf count,
// the match level and branch_enable; level store contents are undefined until written.
module merkle_root_and_branch
  import mrb_pkg::*;
#(
  parameter int TREE_LEVELS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [63:0] leaf_word0,
  input  logic [63:0] leaf_word1,
  input  logic [63:0] leaf_word2,
  input  logic [63:0] leaf_word3,
  input  logic        leaf_matches,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [63:0] hash_word0,
  output logic [63:0] hash_word1,
  output logic [63:0] hash_word2,
  output logic [63:0] hash_word3,
  output logic [62:0] leaf_total,
  output logic        is_last
);

  localparam int LW = $clog2(TREE_LEVELS);
  localparam logic [TREE_LEVELS-1:0] ONE = TREE_LEVELS'(1);
  localparam logic [LVL_W-1:0] LV_TOP = LVL_W'(TREE_LEVELS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHK   = 10'b0000000010,
    S_SIB   = 10'b0000000100,
    S_M1    = 10'b0000001000,
    S_M2    = 10'b0000010000,
    S_SCAN  = 10'b0000100000,
    S_FRD   = 10'b0001000000,
    S_FLOOP = 10'b0010000000,
    S_L1    = 10'b0100000000,
    S_FLUSH = 10'b1000000000
  } state_t;

  state_t state;

  logic                   branch_enable;
  logic [TREE_LEVELS-2:0] leaves_seen;
  logic [LVL_W-1:0]       matched_level;
  logic [TREE_LEVELS-1:0] cnt;
  logic [LVL_W-1:0]       lv;
  logic                   fin;
  logic                   on_path;
  logic [255:0]           acc;

  logic [255:0] lvl_mem [TREE_LEVELS];
  logic [255:0] rdata;
  logic         rd_en;
  logic         wr_en;

  logic         pend_valid;
  logic         pend_kind;
  logic [255:0] pend_hash;
  logic [62:0]  pend_total;
  logic [255:0] out_hash;

  logic         sha_start;
  logic [511:0] sha_blk;
  logic [255:0] sha_init;
  sha_stat_t    sha_stat;
  logic [255:0] sha_dig;

  logic         lv_lt;
  logic [LW-1:0] lv_idx;
  logic         cbit;
  logic         can_emit;
  logic         out_free;
  logic         em_want;
  logic         em_kind;
  logic [255:0] em_hash;
  logic [62:0]  em_total;
  logic         step;
  logic         accept;
  logic         out_load;
  logic         last_load;

  assign lv_lt    = lv < LV_TOP;
  assign lv_idx   = lv[LW-1:0];
  assign cbit     = cnt[lv_idx];
  assign out_free = !out_valid || out_ready;
  assign can_emit = !pend_valid || out_free;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_load = (state == S_FLUSH) && pend_valid && out_free;
  assign out_load  = (em_want && step && pend_valid) || last_load;

  always_comb begin
    em_want  = 1'b0;
    em_kind  = 1'b0;
    em_hash  = '0;
    em_total = '0;
    step     = 1'b1;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    sha_start = 1'b0;
    sha_blk  = {bswap256(rdata), bswap256(acc)};
    sha_init = SHA_IV;
    case (state)
      S_IDLE: begin
        em_want = accept && action && (leaves_seen == '0);
        em_kind = 1'b1;
      end
      S_CHK: begin
        rd_en = lv_lt && !cbit;
        wr_en = !(lv_lt && !cbit) && !fin;
      end
      S_SIB: begin
        em_want = branch_enable && (on_path || matched_level == lv);
        em_hash = on_path ? rdata : acc;
        step = !em_want || can_emit;
        sha_start = step;
      end
      S_M1: begin
        sha_start = sha_stat.done;
        sha_blk = MERGE_PAD;
        sha_init = sha_dig;
      end
      S_SCAN: begin
        rd_en = cbit;
      end
      S_FLOOP: begin
        if (lv_lt && cnt != (ONE << lv)) begin
          em_want = on_path && branch_enable;
          step = !em_want || can_emit;
          sha_start = step;
          sha_blk = {bswap256(acc), 8'h01, 8'h80, 176'd0, 64'd264};
        end else begin
          em_want  = 1'b1;
          em_kind  = 1'b1;
          em_hash  = acc;
          em_total = 63'(leaves_seen);
          step = can_emit;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= lvl_mem[lv_idx];
    end
    if (wr_en) begin
      lvl_mem[lv_idx] <= acc;
    end
  end

  mrb_sha_core u_sha (
    .clk    (clk),
    .rst    (rst),
    .start  (sha_start),
    .blk    (sha_blk),
    .init   (sha_init),
    .stat   (sha_stat),
    .digest (sha_dig)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      branch_enable <= 1'b0;
      leaves_seen   <= '0;
      matched_level <= NO_LEVEL;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        branch_enable <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid  <= 1'b1;
        out_kind   <= pend_kind;
        out_hash   <= pend_hash;
        leaf_total <= pend_total;
        is_last    <= last_load;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // Hold each result in a pending register so the last one of an item can be marked.
      if (em_want && step) begin
        pend_valid <= 1'b1;
        pend_kind  <= em_kind;
        pend_hash  <= em_hash;
        pend_total <= em_total;
      end else if (last_load) begin
        pend_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            lv <= '0;
            if (!action) begin
              if (!(&leaves_seen)) begin
                acc <= {leaf_word3, leaf_word2, leaf_word1, leaf_word0};
                on_path <= (matched_level == NO_LEVEL) && leaf_matches;
                cnt <= {1'b0, leaves_seen} + ONE;
                leaves_seen <= leaves_seen + 1'b1;
                fin <= 1'b0;
                state <= S_CHK;
              end
            end else if (leaves_seen == '0) begin
              matched_level <= NO_LEVEL;
              state <= S_FLUSH;
            end else begin
              cnt <= {1'b0, leaves_seen};
              fin <= 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_CHK: begin
          if (lv_lt && !cbit) begin
            state <= S_SIB;
          end else if (fin) begin
            state <= S_FLOOP;
          end else begin
            if (on_path) begin
              matched_level <= lv;
            end
            state <= S_FLUSH;
          end
        end
        S_SIB: begin
          if (step) begin
            if (!on_path && matched_level == lv) begin
              on_path <= 1'b1;
            end
            state <= S_M1;
          end
        end
        S_M1: begin
          if (sha_stat.done) begin
            state <= S_M2;
          end
        end
        S_M2: begin
          if (sha_stat.done) begin
            acc <= bswap256(sha_dig);
            lv <= lv + 1'b1;
            state <= S_CHK;
          end
        end
        S_SCAN: begin
          if (cbit) begin
            state <= S_FRD;
          end else begin
            lv <= lv + 1'b1;
          end
        end
        S_FRD: begin
          acc <= rdata;
          on_path <= (matched_level == lv);
          state <= S_FLOOP;
        end
        S_FLOOP: begin
          if (step) begin
            if (lv_lt && cnt != (ONE << lv)) begin
              state <= S_L1;
            end else begin
              leaves_seen <= '0;
              matched_level <= NO_LEVEL;
              state <= S_FLUSH;
            end
          end
        end
        S_L1: begin
          if (sha_stat.done) begin
            acc <= bswap256(sha_dig);
            cnt <= cnt + (ONE << lv);
            lv <= lv + 1'b1;
            state <= S_CHK;
          end
        end
        S_FLUSH: begin
          if (!pend_valid || out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign hash_word0 = out_hash[63:0];
  assign hash_word1 = out_hash[127:64];
  assign hash_word2 = out_hash[191:128];
  assign hash_word3 = out_hash[255:192];

`ifndef ASSERT_OFF
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("pending result left when taking a new item");

  a_sha_start_free: assert property (@(posedge clk) disable iff (rst)
    sha_start |-> !sha_stat.busy)
    else $error("hash unit started while busy");

  a_match_range: assert property (@(posedge clk) disable iff (rst)
    matched_level == NO_LEVEL || matched_level < LV_TOP)
    else $error("match level out of range");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLOOP && em_kind && step) |=> leaves_seen == '0)
    else $error("tree state not cleared after root");
`endif

endmodule

// File: tb/sv/merkle_root_and_branch_tb.sv
module merkle_root_and_branch_tb
  import mrb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit           act;
    logic [255:0] words;
    bit           m;
  } leaf_beat_t;

  typedef struct {
    bit           kind;
    logic [255:0] h;
    logic [62:0]  total;
    bit           last;
  } hash_res_t;

  typedef struct {
    leaf_beat_t   beat;
    bit           fixed;
    bit           fkind;
    logic [255:0] fh;
    logic [62:0]  ftotal;
  } dir_row_t;

  localparam bit ACT_PUSH   = 1'b0;
  localparam bit ACT_FINISH = 1'b1;
  localparam bit KIND_BRANCH = 1'b0;
  localparam bit KIND_ROOT   = 1'b1;
  localparam logic [63:0] LEAF_CAP = (64'd1 << 63) - 64'd1;

  localparam logic [31:0] RC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [63:0] leaf_word0, leaf_word1, leaf_word2, leaf_word3;
  logic        leaf_matches;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [63:0] hash_word0, hash_word1, hash_word2, hash_word3;
  logic [62:0] leaf_total;
  logic        is_last;

  merkle_root_and_branch DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action),
    .leaf_word0(leaf_word0), .leaf_word1(leaf_word1),
    .leaf_word2(leaf_word2), .leaf_word3(leaf_word3),
    .leaf_matches(leaf_matches),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind),
    .hash_word0(hash_word0), .hash_word1(hash_word1),
    .hash_word2(hash_word2), .hash_word3(hash_word3),
    .leaf_total(leaf_total), .is_last(is_last)
  );

  // predictor state
  logic [255:0] lvl_store [64];
  logic [63:0]  leaves_cnt;
  logic [6:0]   match_lvl;
  bit           branch_on;

  hash_res_t step_out[$];
  hash_res_t root_branch_q[$];
  dir_row_t  dir_rows[$];

  int mismatches;
  int failures;
  int burst_left;
  bit hold_req;
  bit hold_done;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_block(input logic [255:0] st, input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = st;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + RC[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {st[255:224] + a, st[223:192] + b, st[191:160] + c, st[159:128] + d,
            st[127:96] + e, st[95:64] + f, st[63:32] + g, st[31:0] + h};
  endfunction

  // hash words hold byte 0 lowest; messages and digests hold byte 0 highest
  function automatic logic [255:0] flip_bytes(input logic [255:0] x);
    logic [255:0] r;
    for (int i = 0; i < 32; i++) r[255-8*i -: 8] = x[8*i +: 8];
    return r;
  endfunction

  function automatic logic [255:0] merge_hash(input logic [255:0] l, input logic [255:0] r);
    logic [255:0] st;
    st = sha_block(H_INIT, {flip_bytes(l), flip_bytes(r)});
    st = sha_block(st, {8'h80, 440'd0, 64'd512});
    return flip_bytes(st);
  endfunction

  function automatic logic [255:0] lift_hash(input logic [255:0] x);
    return flip_bytes(sha_block(H_INIT, {flip_bytes(x), 8'h01, 8'h80, 176'd0, 64'd264}));
  endfunction

  function automatic void emit(input bit kind, input logic [255:0] h, input logic [62:0] tot);
    hash_res_t r;
    r.kind = kind; r.h = h; r.total = tot; r.last = 0;
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic void exp_add(input hash_res_t r);
    root_branch_q.insert(root_branch_q.size(), r);
  endfunction

  function automatic void add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void tree_step(input leaf_beat_t bt);
    logic [255:0] acc, sib;
    logic [63:0]  c;
    bit           on_path;
    int           lv;
    step_out.delete();
    if (bt.act == ACT_PUSH) begin
      if (leaves_cnt >= LEAF_CAP) return;
      acc = bt.words;
      on_path = (match_lvl == NO_LEVEL) && bt.m;
      leaves_cnt = leaves_cnt + 1;
      c = leaves_cnt;
      lv = 0;
      while (lv < 64 && !c[lv]) begin
        sib = lvl_store[lv];
        if (on_path) begin
          if (branch_on) emit(KIND_BRANCH, sib, '0);
        end else if (int'(match_lvl) == lv) begin
          if (branch_on) emit(KIND_BRANCH, acc, '0);
          on_path = 1;
        end
        acc = merge_hash(sib, acc);
        lv++;
      end
      if (lv < 64) begin
        lvl_store[lv] = acc;
        if (on_path) match_lvl = lv[6:0];
      end
    end else begin
      c = leaves_cnt;
      if (c == 0) begin
        emit(KIND_ROOT, '0, '0);
      end else begin
        lv = 0;
        while (lv < 63 && !c[lv]) lv++;
        acc = lvl_store[lv];
        on_path = (int'(match_lvl) == lv);
        while (lv < 64 && c != (64'd1 << lv)) begin
          if (on_path && branch_on) emit(KIND_BRANCH, '0, '0);
          acc = lift_hash(acc);
          c = c + (64'd1 << lv);
          lv++;
          while (lv < 64 && !c[lv]) begin
            sib = lvl_store[lv];
            if (on_path) begin
              if (branch_on) emit(KIND_BRANCH, sib, '0);
            end else if (int'(match_lvl) == lv) begin
              if (branch_on) emit(KIND_BRANCH, acc, '0);
              on_path = 1;
            end
            acc = merge_hash(sib, acc);
            lv++;
          end
        end
        emit(KIND_ROOT, acc, leaves_cnt[62:0]);
      end
      leaves_cnt = 0;
      match_lvl = NO_LEVEL;
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
  endfunction

  function automatic logic [255:0] rand_hash();
    logic [255:0] h;
    case ($urandom_range(0, 9))
      0: h = '0;
      1: h = '1;
      default: begin
        for (int i = 0; i < 8; i++) h[32*i +: 32] = $urandom;
      end
    endcase
    return h;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // drive one beat; valid stays up across a burst and drops only for a gap
  task automatic send_beat(input leaf_beat_t bt, input bit fixed, input hash_res_t fres);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    action       <= bt.act;
    leaf_word0   <= bt.words[63:0];
    leaf_word1   <= bt.words[127:64];
    leaf_word2   <= bt.words[191:128];
    leaf_word3   <= bt.words[255:192];
    leaf_matches <= bt.m;
    in_valid     <= 1;
    do @(posedge clk); while (!in_ready);
    tree_step(bt);
    if (fixed) begin
      exp_add(fres);
    end else begin
      foreach (step_out[i]) exp_add(step_out[i]);
    end
    burst_left--;
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 0;
    burst_left = 0;
    while (root_branch_q.size() != 0) @(negedge clk);
    // a push with no result may still be merging
    repeat (2000) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  task automatic write_branch_enable(input bit v);
    cfg_wr_en   <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 0;
    branch_on = v;
  endtask

  task automatic random_trees(input int count);
    leaf_beat_t bt;
    hash_res_t  none;
    int sent, n;
    none = '{default: '0};
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 19) == 0) begin
        bt.act = ACT_FINISH; bt.words = rand_hash(); bt.m = $urandom_range(0, 1);
        send_beat(bt, 0, none);
        sent++;
      end
      n = $urandom_range(0, 99) < 85 ? $urandom_range(1, 12) : $urandom_range(13, 70);
      for (int i = 0; i < n; i++) begin
        bt.act = ACT_PUSH; bt.words = rand_hash(); bt.m = $urandom_range(0, 3) == 0;
        send_beat(bt, 0, none);
        sent++;
      end
      // leave a few trees open so the next one piles onto them
      if ($urandom_range(0, 9) != 0) begin
        bt.act = ACT_FINISH; bt.words = rand_hash(); bt.m = $urandom_range(0, 1);
        send_beat(bt, 0, none);
        sent++;
      end
    end
  endtask

  function automatic dir_row_t row(input bit act, input logic [255:0] w, input bit m);
    dir_row_t r;
    r.beat.act = act; r.beat.words = w; r.beat.m = m;
    r.fixed = 0; r.fkind = 0; r.fh = '0; r.ftotal = '0;
    return r;
  endfunction

  function automatic dir_row_t row_fixed(input bit act, input logic [255:0] w, input bit m,
                                         input bit k, input logic [255:0] h,
                                         input logic [62:0] t);
    dir_row_t r;
    r = row(act, w, m);
    r.fixed = 1; r.fkind = k; r.fh = h; r.ftotal = t;
    return r;
  endfunction

  initial begin
    hash_res_t fr;
    logic [255:0] one_leaf;
    rst = 1; cfg_wr_en = 0; cfg_wr_data = 0; in_valid = 0; action = 0;
    leaf_word0 = 0; leaf_word1 = 0; leaf_word2 = 0; leaf_word3 = 0; leaf_matches = 0;
    leaves_cnt = 0; match_lvl = NO_LEVEL; branch_on = 0;
    burst_left = 0; hold_req = 0;
    for (int i = 0; i < 64; i++) lvl_store[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    one_leaf = {64'h0123456789abcdef, 64'hfedcba9876543210, 64'h1, 64'h8000000000000000};
    // empty tree right after reset, branch output still off
    add_row(row_fixed(ACT_FINISH, '0, 0, KIND_ROOT, '0, '0));
    add_row(row(ACT_PUSH, one_leaf, 1));
    add_row(row_fixed(ACT_FINISH, '1, 1, KIND_ROOT, one_leaf, 63'd1));
    add_row(row(ACT_PUSH, '1, 0));
    add_row(row(ACT_PUSH, '0, 1));
    add_row(row(ACT_PUSH, {8{32'haaaaaaaa}}, 0));
    add_row(row(ACT_FINISH, '0, 0));
    foreach (dir_rows[i]) begin
      fr.kind = dir_rows[i].fkind; fr.h = dir_rows[i].fh;
      fr.total = dir_rows[i].ftotal; fr.last = 1;
      send_beat(dir_rows[i].beat, dir_rows[i].fixed, fr);
    end
    go_idle();
    write_branch_enable(1);
    dir_rows.delete();
    add_row(row_fixed(ACT_FINISH, '1, 1, KIND_ROOT, '0, '0));
    add_row(row(ACT_PUSH, '1, 1));
    // the partner of the matched leaf comes out as its sibling
    add_row(row_fixed(ACT_PUSH, '0, 0, KIND_BRANCH, '0, '0));
    add_row(row(ACT_PUSH, {8{32'h55555555}}, 1));
    add_row(row(ACT_FINISH, '0, 0));
    add_row(row(ACT_PUSH, {8{32'h12345678}}, 0));
    add_row(row(ACT_PUSH, {8{32'h9abcdef0}}, 0));
    add_row(row(ACT_PUSH, {8{32'hdeadbeef}}, 1));
    add_row(row(ACT_PUSH, {8{32'h0f0f0f0f}}, 1));
    add_row(row(ACT_PUSH, {8{32'hf0f0f0f0}}, 0));
    add_row(row(ACT_FINISH, '0, 0));
    for (int i = 0; i < 6; i++) add_row(row(ACT_PUSH, {8{$urandom}}, i == 4));
    add_row(row(ACT_FINISH, '0, 0));
    foreach (dir_rows[i]) begin
      fr.kind = dir_rows[i].fkind; fr.h = dir_rows[i].fh;
      fr.total = dir_rows[i].ftotal; fr.last = 1;
      send_beat(dir_rows[i].beat, dir_rows[i].fixed, fr);
    end

    go_idle();
    hold_req = 1;
    random_trees(150);
    go_idle();
    write_branch_enable(0);
    random_trees(130);
    go_idle();
    write_branch_enable(1);
    random_trees(150);

    in_valid <= 0;
    while (root_branch_q.size() != 0) @(negedge clk);
    repeat (2000) @(posedge clk);
    if (failures == 0 && mismatches == 0 && root_branch_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: one long hold-off on request, otherwise a changing stall pattern
  initial begin
    int cyc;
    int mode;
    out_ready = 0;
    hold_done = 0;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        hold_done = 1;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= (cyc % 5) != 0;
      endcase
      cyc++;
    end
  end

  initial begin
    mismatches = 0;
    failures = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (root_branch_q.size() == 0) begin
          failures++;
          if (failures + mismatches <= 10)
            $display("unexpected result beat kind=%0d h=%h", out_kind,
                     {hash_word3, hash_word2, hash_word1, hash_word0});
        end else begin
          hash_res_t e;
          e = root_branch_q.pop_front();
          if (out_kind !== e.kind || is_last !== e.last || leaf_total !== e.total ||
              {hash_word3, hash_word2, hash_word1, hash_word0} !== e.h) begin
            mismatches++;
            if (failures + mismatches <= 10) begin
              $display("mismatch exp kind=%0d last=%0d total=%0d h=%h", e.kind, e.last,
                       e.total, e.h);
              $display("         got kind=%0d last=%0d total=%0d h=%h", out_kind, is_last,
                       leaf_total, {hash_word3, hash_word2, hash_word1, hash_word0});
            end
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
